@@ design/sbfd_pkg.sv @@
package sbfd_pkg;

    localparam logic [7:0] SBUS_HEADER = 8'h0F;
    localparam int FRAME_BYTES  = 25;
    localparam int DATA_BYTES   = FRAME_BYTES - 1;
    localparam int CHANNEL_BITS = 11;
    localparam int BUF_BITS     = CHANNEL_BITS + 7;

    typedef logic [7:0]                byte_t;
    typedef logic [CHANNEL_BITS-1:0]   chan_value_t;
    typedef logic [3:0]                chan_index_t;
    typedef logic [4:0]                frame_pos_t;
    typedef logic [4:0]                bit_count_t;
    typedef logic [BUF_BITS-1:0]       bit_buf_t;

    // status from the unpacker back to the frame control
    typedef struct packed {
        logic busy;
        logic pull;
    } unpack_stat_t;

endpackage

@@ design/sbfd_in_if.sv @@
interface sbfd_in_if;
    logic                 valid;
    logic                 ready;
    sbfd_pkg::byte_t      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/sbfd_out_if.sv @@
interface sbfd_out_if;
    logic                   valid;
    logic                   ready;
    sbfd_pkg::chan_index_t  channel_index;
    sbfd_pkg::chan_value_t  channel_value;
    logic                   last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

@@ design/sbus_frame_channel_decoder.sv @@
// Serial-bus frame decoder.
// rx (valid/ready) takes one received byte per item. Outside a frame every
// byte but the header 0x0F is dropped; a header opens a frame and the next
// 24 bytes shift into a chain of byte cells, one cell step per byte.
// After the 25th byte the chain shifts its bytes, lowest first, into a bit
// buffer, and each 11-bit channel leaves on chan (valid/ready) with its
// index; last_channel marks channel NUM_CHANNELS-1.
// Bytes are taken only while no unpack runs. The 25th byte starts the
// unpack: the busy flag is set, bytes are pulled from the chain into the
// bit buffer, and each channel is loaded into the output register.
// Each unpack step either pulls one byte, while the buffer holds under one
// channel, or sends one channel out; rx.ready stays low meanwhile.
// A stall on chan holds the output register; the unpack tops up the bit
// buffer to one channel and then waits with the chain frozen.
// Reset clears the frame position, so the block waits for a header, and
// empties the output register. The cells need no reset.
module sbus_frame_channel_decoder #(
    parameter int NUM_CHANNELS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    sbfd_in_if.sink    rx,
    sbfd_out_if.source chan
);
    import sbfd_pkg::*;

    localparam frame_pos_t LAST_POS = frame_pos_t'(FRAME_BYTES - 1);

    frame_pos_t   pos_reg;
    frame_pos_t   pos_next;
    logic         accept;
    logic         is_header;
    logic         load;
    logic         start;
    unpack_stat_t stat;
    byte_t        feed;
    byte_t        cell_q [DATA_BYTES];

    assign rx.ready  = !stat.busy;
    assign accept    = rx.valid && rx.ready;
    assign is_header = (rx.rx_byte == SBUS_HEADER);
    // header is not kept; later bytes of a frame go into the chain
    assign load      = accept && (pos_reg != '0);
    assign start     = accept && (pos_reg == LAST_POS);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                pos_next = is_header ? 5'd1 : 5'd0;
            end
            else if (pos_reg == LAST_POS)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // new bytes enter at the top; unpack pulls from cell 0
    assign feed = load ? rx.rx_byte : '0;

    for (genvar i = 0; i < DATA_BYTES; i++)
    begin : g_cell
        byte_t d_in;
        if (i == DATA_BYTES - 1)
        begin : g_top
            assign d_in = feed;
        end
        else
        begin : g_mid
            assign d_in = cell_q[i+1];
        end
        sbfd_cell u_cell (
            .clk   (clk),
            .shift (load || stat.pull),
            .d_in  (d_in),
            .d_out (cell_q[i])
        );
    end

    sbfd_unpack #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .head_byte (cell_q[0]),
        .stat      (stat),
        .chan      (chan)
    );
endmodule

@@ design/sbfd_cell.sv @@
module sbfd_cell (
    input  logic            clk,
    input  logic            shift,
    input  sbfd_pkg::byte_t d_in,
    output sbfd_pkg::byte_t d_out
);
    import sbfd_pkg::*;

    byte_t data_reg;

    // take the neighbor's byte on each shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;
endmodule

@@ design/sbfd_unpack.sv @@
module sbfd_unpack #(
    parameter int NUM_CHANNELS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sbfd_pkg::byte_t       head_byte,
    output sbfd_pkg::unpack_stat_t stat,
    sbfd_out_if.source            chan
);
    import sbfd_pkg::*;

    localparam chan_index_t LAST_INDEX = chan_index_t'(NUM_CHANNELS - 1);
    localparam bit_count_t  CH_BITS    = bit_count_t'(CHANNEL_BITS);

    logic        busy_reg;
    bit_count_t  cnt_reg;
    bit_buf_t    buf_reg;
    chan_index_t idx_reg;
    logic        ovalid_reg;
    chan_index_t oindex_reg;
    chan_value_t ovalue_reg;
    logic        olast_reg;

    logic        pull;
    logic        emit;
    logic        emit_last;

    // pull a byte from the chain until a whole channel is buffered
    assign pull      = busy_reg && (cnt_reg < CH_BITS);
    assign emit      = busy_reg && (cnt_reg >= CH_BITS) && (!ovalid_reg || chan.ready);
    assign emit_last = emit && (idx_reg == LAST_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            buf_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            // load a new output item on emit, drop it once taken
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (chan.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                buf_reg  <= '0;
                idx_reg  <= '0;
            end
            else if (pull)
            begin
                buf_reg <= buf_reg | (bit_buf_t'(head_byte) << cnt_reg);
                cnt_reg <= cnt_reg + 5'd8;
            end
            else if (emit)
            begin
                buf_reg    <= buf_reg >> CHANNEL_BITS;
                cnt_reg    <= cnt_reg - CH_BITS;
                idx_reg    <= idx_reg + 4'd1;
                if (emit_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // hold the output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oindex_reg <= idx_reg;
            ovalue_reg <= buf_reg[CHANNEL_BITS-1:0];
            olast_reg  <= emit_last;
        end
    end

    assign stat.busy          = busy_reg;
    assign stat.pull          = pull;
    assign chan.valid         = ovalid_reg;
    assign chan.channel_index = oindex_reg;
    assign chan.channel_value = ovalue_reg;
    assign chan.last_channel  = olast_reg;
endmodule
